FILE: design/pse_pkg.sv
`default_nettype none
package pse_pkg;

  typedef struct packed {
    logic       command;
    logic [9:0] prime_index;
  } request_t;

  typedef struct packed {
    logic [11:0] prime_value;
    logic [9:0]  prime_count;
    logic        found;
  } result_t;

  localparam logic CMD_BUILD = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  localparam int PC_W = 4;

  localparam logic [PC_W-1:0] STEP_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] STEP_INIT  = 4'd1;
  localparam logic [PC_W-1:0] STEP_FILL  = 4'd2;
  localparam logic [PC_W-1:0] STEP_SETI  = 4'd3;
  localparam logic [PC_W-1:0] STEP_OTEST = 4'd4;
  localparam logic [PC_W-1:0] STEP_OCHK  = 4'd5;
  localparam logic [PC_W-1:0] STEP_INNER = 4'd6;
  localparam logic [PC_W-1:0] STEP_ONEXT = 4'd7;
  localparam logic [PC_W-1:0] STEP_PINIT = 4'd8;
  localparam logic [PC_W-1:0] STEP_PTEST = 4'd9;
  localparam logic [PC_W-1:0] STEP_PCHK  = 4'd10;
  localparam logic [PC_W-1:0] STEP_DONE  = 4'd11;
  localparam logic [PC_W-1:0] STEP_FETCH = 4'd12;

  typedef enum logic [1:0] {
    SEQ_DISPATCH,
    SEQ_BRANCH,
    SEQ_LOOP,
    SEQ_JUMP
  } seq_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_I_EQ_N,
    COND_I_GT_N,
    COND_J_GT_N,
    COND_MARK_CLR
  } cond_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_IDLE,
    ACT_INIT,
    ACT_FILL,
    ACT_SET2,
    ACT_LOADJ,
    ACT_CLEAR,
    ACT_INCI,
    ACT_PINIT,
    ACT_PACK,
    ACT_DONE,
    ACT_FETCH
  } act_t;

  typedef struct packed {
    seq_t            seq;
    cond_t           cond;
    logic [PC_W-1:0] target;
    act_t            act;
  } ucode_t;

  typedef struct packed {
    logic i_eq_n;
    logic i_gt_n;
    logic j_gt_n;
    logic mark_clr;
  } flags_t;

  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{seq: SEQ_JUMP, cond: COND_NONE, target: STEP_IDLE, act: ACT_NONE};
    unique case (pc)
      STEP_IDLE:  w = '{SEQ_DISPATCH, COND_NONE,     STEP_FETCH, ACT_IDLE};
      STEP_INIT:  w = '{SEQ_JUMP,     COND_NONE,     STEP_FILL,  ACT_INIT};
      STEP_FILL:  w = '{SEQ_LOOP,     COND_I_EQ_N,   STEP_SETI,  ACT_FILL};
      STEP_SETI:  w = '{SEQ_JUMP,     COND_NONE,     STEP_OTEST, ACT_SET2};
      STEP_OTEST: w = '{SEQ_BRANCH,   COND_I_GT_N,   STEP_PINIT, ACT_NONE};
      STEP_OCHK:  w = '{SEQ_BRANCH,   COND_MARK_CLR, STEP_ONEXT, ACT_LOADJ};
      STEP_INNER: w = '{SEQ_LOOP,     COND_J_GT_N,   STEP_ONEXT, ACT_CLEAR};
      STEP_ONEXT: w = '{SEQ_JUMP,     COND_NONE,     STEP_OTEST, ACT_INCI};
      STEP_PINIT: w = '{SEQ_JUMP,     COND_NONE,     STEP_PTEST, ACT_PINIT};
      STEP_PTEST: w = '{SEQ_BRANCH,   COND_I_GT_N,   STEP_DONE,  ACT_NONE};
      STEP_PCHK:  w = '{SEQ_JUMP,     COND_NONE,     STEP_PTEST, ACT_PACK};
      STEP_DONE:  w = '{SEQ_JUMP,     COND_NONE,     STEP_IDLE,  ACT_DONE};
      STEP_FETCH: w = '{SEQ_JUMP,     COND_NONE,     STEP_IDLE,  ACT_FETCH};
      default:    w = '{SEQ_JUMP,     COND_NONE,     STEP_IDLE,  ACT_NONE};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

FILE: design/pse_ram.sv
`default_nettype none
module pse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: design/pse_seq.sv
`default_nettype none
module pse_seq
  import pse_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   start,
  input  wire logic   command,
  input  wire flags_t flags,
  output act_t        act,
  output logic        busy
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  ucode_t          word;
  logic            cond_hit;
  logic            accept;

  assign word   = ucode(pc);
  assign act    = word.act;
  assign busy   = (pc != STEP_IDLE);
  assign accept = start && !busy;

  always_comb begin
    unique case (word.cond)
      COND_I_EQ_N:   cond_hit = flags.i_eq_n;
      COND_I_GT_N:   cond_hit = flags.i_gt_n;
      COND_J_GT_N:   cond_hit = flags.j_gt_n;
      COND_MARK_CLR: cond_hit = flags.mark_clr;
      default:       cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    unique case (word.seq)
      SEQ_DISPATCH: begin
        if (!accept) begin
          pc_next = pc;
        end else if (command == CMD_FETCH) begin
          pc_next = word.target;
        end else begin
          pc_next = pc + 1'b1;
        end
      end
      SEQ_BRANCH: pc_next = cond_hit ? word.target : pc + 1'b1;
      SEQ_LOOP:   pc_next = cond_hit ? word.target : pc;
      default:    pc_next = word.target;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule
`default_nettype wire

FILE: design/pse_dp.sv
`default_nettype none
module pse_dp
  import pse_pkg::*;
#(
  parameter int MAX_LIMIT   = 4095,
  parameter int PRIME_SLOTS = 1024
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire act_t     act,
  input  wire request_t request,
  input  wire logic [11:0] limit,
  output flags_t        flags,
  output logic          done,
  output result_t       result
);

  localparam int MARK_DEPTH = MAX_LIMIT + 1;
  localparam int MARK_AW    = $clog2(MARK_DEPTH);
  localparam int NW         = MARK_AW + 1;
  localparam int SLOT_AW    = $clog2(PRIME_SLOTS);
  localparam int CW         = $clog2(PRIME_SLOTS + 1);
  localparam int LW         = NW + 12;
  localparam int QW         = CW + 10;

  logic [NW-1:0] i;
  logic [NW-1:0] j;
  logic [NW-1:0] n;
  logic [CW-1:0] cnt;
  logic [CW-1:0] primes_found;
  logic          found_r;

  logic [LW-1:0] lim_w;
  logic [LW-1:0] max_w;
  logic [NW-1:0] n_sat;

  logic               mark_we;
  logic [MARK_AW-1:0] mark_waddr;
  logic               mark_wdata;
  logic               mark_rdata;

  logic               list_we;
  logic [SLOT_AW-1:0] list_raddr;
  logic [11:0]        list_rdata;
  logic [LW-1:0]      i_w;
  logic [SLOT_AW+9:0] idx_w;

  logic [QW-1:0] q_idx;
  logic [QW-1:0] q_pf;
  logic [QW-1:0] q_slots;
  logic [QW-1:0] q_src;
  logic [9:0]    count_field;
  logic          fetch_hit;
  logic          room;

  assign lim_w = LW'(limit);
  assign max_w = LW'(MAX_LIMIT);
  assign n_sat = (lim_w > max_w) ? max_w[NW-1:0] : lim_w[NW-1:0];

  assign flags.i_eq_n   = (i == n);
  assign flags.i_gt_n   = (i > n);
  assign flags.j_gt_n   = (j > n);
  assign flags.mark_clr = !mark_rdata;

  always_comb begin
    mark_we    = 1'b0;
    mark_waddr = i[MARK_AW-1:0];
    mark_wdata = 1'b1;
    if (act == ACT_FILL) begin
      mark_we = 1'b1;
    end else if (act == ACT_CLEAR) begin
      mark_we    = !flags.j_gt_n;
      mark_waddr = j[MARK_AW-1:0];
      mark_wdata = 1'b0;
    end
  end

  pse_ram #(.WIDTH(1), .DEPTH(MARK_DEPTH)) u_marks (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .raddr (i[MARK_AW-1:0]),
    .rdata (mark_rdata)
  );

  assign room    = (cnt < CW'(PRIME_SLOTS));
  assign list_we = (act == ACT_PACK) && mark_rdata && room;
  assign i_w     = LW'(i);
  assign idx_w   = (SLOT_AW + 10)'(request.prime_index);
  assign list_raddr = idx_w[SLOT_AW-1:0];

  pse_ram #(.WIDTH(12), .DEPTH(PRIME_SLOTS)) u_list (
    .clk   (clk),
    .we    (list_we),
    .waddr (cnt[SLOT_AW-1:0]),
    .wdata (i_w[11:0]),
    .raddr (list_raddr),
    .rdata (list_rdata)
  );

  assign q_idx     = QW'(request.prime_index);
  assign q_pf      = QW'(primes_found);
  assign q_slots   = QW'(PRIME_SLOTS);
  assign fetch_hit = (q_idx < q_pf) && (q_idx < q_slots);

  // count saturates at the field's range
  assign q_src       = (act == ACT_DONE) ? QW'(cnt) : QW'(primes_found);
  assign count_field = (q_src > QW'(1023)) ? 10'd1023 : q_src[9:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      primes_found <= '0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (act)
        ACT_DONE: begin
          primes_found <= cnt;
          done         <= 1'b1;
        end
        ACT_FETCH: begin
          done <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (act)
      ACT_IDLE:  found_r <= fetch_hit;
      ACT_INIT: begin
        i <= '0;
        n <= n_sat;
      end
      ACT_FILL:  i <= i + 1'b1;
      ACT_SET2:  i <= NW'(2);
      ACT_LOADJ: j <= {i[NW-2:0], 1'b0};
      ACT_CLEAR: j <= j + i;
      ACT_INCI:  i <= i + 1'b1;
      ACT_PINIT: begin
        i   <= NW'(2);
        cnt <= '0;
      end
      ACT_PACK: begin
        i <= i + 1'b1;
        if (mark_rdata && room) begin
          cnt <= cnt + 1'b1;
        end
      end
      ACT_DONE: begin
        result.prime_value <= '0;
        result.prime_count <= count_field;
        result.found       <= 1'b0;
      end
      ACT_FETCH: begin
        result.prime_value <= found_r ? list_rdata : 12'd0;
        result.prime_count <= count_field;
        result.found       <= found_r;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: design/prime_sieve_engine.sv
`default_nettype none
// prime sieve engine: builds a prime table up to sieve_limit, then serves lookups
// request channel: an item is taken on a clock edge with start high and busy low;
//   command build sieves up to sieve_limit, command fetch reads prime_index
// result channel: done is high for one cycle with result valid; every item
//   gives exactly one result and the receiver cannot stall it
// fetch: the accepting edge moves the sequencer to its fetch step, which
//   registers done and result; a new item can be taken in the strobe cycle
// build: sieves up to n, the saturated limit; result strobe in the cycle
//   after the done step; the microcode fills, sieves, then packs, one mark
//   access per step
// configuration: one register, sieve_limit at byte address 0, reads return it;
//   the user makes apb writes only while the engine is idle; it is not enforced
// reset: sequencer returns to idle, prime count clears to zero, sieve_limit
//   goes to 4095; mark and prime memories are not cleared, no result uses
//   them before a build writes them
module prime_sieve_engine
  import pse_pkg::*;
#(
  parameter int MAX_LIMIT   = 4095,
  parameter int PRIME_SLOTS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        start,
  input  wire request_t    request,
  output logic             busy,
  output logic             done,
  output result_t          result
);

  logic [11:0] sieve_limit;
  act_t        act;
  flags_t      flags;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {20'd0, sieve_limit};

  always_ff @(posedge clk) begin
    if (rst) begin
      sieve_limit <= 12'd4095;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      sieve_limit <= pwdata[11:0];
    end
  end

  pse_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (request.command),
    .flags   (flags),
    .act     (act),
    .busy    (busy)
  );

  pse_dp #(.MAX_LIMIT(MAX_LIMIT), .PRIME_SLOTS(PRIME_SLOTS)) u_dp (
    .clk     (clk),
    .rst     (rst),
    .act     (act),
    .request (request),
    .limit   (sieve_limit),
    .flags   (flags),
    .done    (done),
    .result  (result)
  );

endmodule
`default_nettype wire

FILE: test/prime_result_checker.sv
`timescale 1ns / 1ps
module prime_result_checker
  import pse_pkg::*;
#(
  parameter logic [2:0] LIMIT_ADDR = 3'd0
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic [31:0] prdata,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire request_t    request,
  input  wire logic        done,
  input  wire result_t     result,
  output int               mismatches,
  output int               pending_n
);

  logic [11:0] sieve_limit;
  bit          is_candidate [0:4095];
  logic [11:0] expected_primes [0:1023];
  int          prime_total;
  result_t     pending_results[$];
  int          err_n;

  task automatic compute_primes(input logic [11:0] lim);
    int n;
    int total;
    n     = lim;
    total = 0;
    for (int i = 0; i <= n; i++) is_candidate[i] = 1'b1;
    for (int i = 2; i <= n; i++) begin
      if (is_candidate[i]) begin
        for (int j = 2 * i; j <= n; j += i) is_candidate[j] = 1'b0;
      end
    end
    for (int i = 2; i <= n; i++) begin
      if (is_candidate[i] && total < 1024) begin
        expected_primes[total] = 12'(i);
        total++;
      end
    end
    prime_total = total;
  endtask

  task automatic report(input string msg);
    if (err_n < 10) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    err_n++;
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    logic [9:0] shown_count;
    if (rst) begin
      sieve_limit = 12'd4095;
      prime_total = 0;
      pending_results.delete();
      err_n = 0;
    end else begin
      if (done) begin
        if (pending_results.size() == 0) begin
          report($sformatf("unexpected result value=%0d count=%0d found=%0d",
                           result.prime_value, result.prime_count, result.found));
        end else begin
          want = pending_results.pop_front();
          if (result.prime_value !== want.prime_value) begin
            report($sformatf("prime_value expected %0d got %0d",
                             want.prime_value, result.prime_value));
          end
          if (result.prime_count !== want.prime_count) begin
            report($sformatf("prime_count expected %0d got %0d",
                             want.prime_count, result.prime_count));
          end
          if (result.found !== want.found) begin
            report($sformatf("found expected %0d got %0d", want.found, result.found));
          end
        end
      end
      if (psel && penable && pready && paddr == LIMIT_ADDR) begin
        if (pwrite) begin
          sieve_limit = pwdata[11:0];
        end else if (prdata[11:0] !== sieve_limit) begin
          report($sformatf("sieve_limit read expected %0d got %0d", sieve_limit, prdata[11:0]));
        end
      end
      if (start && !busy) begin
        if (request.command == CMD_BUILD) begin
          compute_primes(sieve_limit);
        end
        shown_count = (prime_total > 1023) ? 10'd1023 : 10'(prime_total);
        want.prime_count = shown_count;
        if (request.command == CMD_FETCH && int'(request.prime_index) < prime_total) begin
          want.prime_value = expected_primes[request.prime_index];
          want.found       = 1'b1;
        end else begin
          want.prime_value = '0;
          want.found       = 1'b0;
        end
        pending_results.push_back(want);
      end
    end
    mismatches <= err_n;
    pending_n  <= pending_results.size();
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import pse_pkg::*;

  localparam int         CYCLE_LIMIT = 5000000;
  localparam logic [2:0] LIMIT_ADDR  = 3'd0;
  localparam logic [2:0] SPARE_ADDR  = 3'd4;

  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start   = 1'b0;
  request_t    request = '0;
  logic        busy;
  logic        done;
  result_t     result;

  int fail_count;
  int pending_n;
  int cycles = 0;
  int sender_idle_pct = 0;
  int pct_table [3] = '{0, 60, 9};
  int lim;
  int pick;

  always #4 clk = ~clk;

  prime_sieve_engine dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  prime_result_checker #(.LIMIT_ADDR(LIMIT_ADDR)) u_check (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .start      (start),
    .busy       (busy),
    .request    (request),
    .done       (done),
    .result     (result),
    .mismatches (fail_count),
    .pending_n  (pending_n)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic issue(input request_t req);
    int gap;
    start   <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start   <= 1'b0;
      request <= request_t'($bits(request_t)'($urandom()));
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic build_sieve();
    issue('{command: CMD_BUILD, prime_index: 10'($urandom())});
  endtask

  task automatic fetch(input logic [9:0] idx);
    issue('{command: CMD_FETCH, prime_index: idx});
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_n != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] value);
    settle();
    apb_access(1'b1, LIMIT_ADDR, value);
    apb_access(1'b0, LIMIT_ADDR, '0);
    apb_access(1'b1, SPARE_ADDR, $urandom());
    apb_access(1'b0, LIMIT_ADDR, '0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fetch with no build yet
    fetch(10'd0);
    fetch(10'h3ff);

    // tiny limits, including ones with no primes
    for (int l = 0; l < 4; l++) begin
      configure(($urandom() & 32'hffff_f000) | 32'(l));
      build_sieve();
      fetch(10'd0);
      fetch(10'd1);
    end

    // upper data bits must be dropped
    configure(32'hffff_f00d);
    build_sieve();
    fetch(10'd5);
    fetch(10'd6);

    configure(32'd4095);
    build_sieve();
    fetch(10'd563);
    fetch(10'd564);
    fetch(10'h3ff);

    for (int phase = 0; phase < 12; phase++) begin
      sender_idle_pct = pct_table[phase % 3];
      lim = (phase % 4 == 3) ? $urandom_range(2048, 4095) : $urandom_range(0, 400);
      configure(($urandom() & 32'hffff_f000) | 32'(lim));
      build_sieve();
      repeat (90) begin
        pick = $urandom_range(99);
        if (pick < 3) begin
          build_sieve();
        end else if (pick < 55) begin
          fetch(10'($urandom_range(0, lim / 8 + 1)));
        end else begin
          fetch(10'($urandom_range(0, 1023)));
        end
      end
    end

    start <= 1'b0;
    while (pending_n != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_n == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: prime_sieve_engine.f
design/pse_pkg.sv
design/pse_ram.sv
design/pse_seq.sv
design/pse_dp.sv
design/prime_sieve_engine.sv
test/prime_result_checker.sv
test/tb_top.sv
